/* rtl/trtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trtc_pkg
// Shared types and constants for the two-rail transposition cipher.
// ----------------------------------------------------------------------------
package trtc_pkg;

    localparam int MAX_LEN_DEF = 64;

    typedef enum logic {
        S_LOAD = 1'b0,
        S_EMIT = 1'b1
    } t_state;

endpackage

/* rtl/two_rail_transposition_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_rail_transposition_cipher
// Buffers one message and emits it permuted over two rails.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while busy is low; the byte with the end mark
// closes the message and the block turns busy. It then reads the message
// buffer through its one registered read port once per byte. Results appear
// on o_strobe in the cycle after each read and cannot be stalled; the last
// result of a run shows up in the first cycle busy is low again, so loading
// of the next message overlaps it. Bytes beyond MAX_LEN are dropped and
// o_overflow is set on every result of that run. The decrypt mode register
// is sampled while the run is emitted.
// ----------------------------------------------------------------------------
module two_rail_transposition_cipher #(
    parameter int MAX_LEN = trtc_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    output logic       o_strobe,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);

    trtc_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_half, n_half;
    logic [AW-1:0] r_k, n_k;
    logic          r_ovf, n_ovf;
    logic          r_decrypt;
    logic          r_rd_vld, n_rd_vld;
    logic          r_rd_last, n_rd_last;
    logic          r_rd_ovf, n_rd_ovf;

    logic          req;
    logic          full;
    logic          wr_en;
    logic [CW-1:0] src;
    logic [CW-1:0] k_ext;
    logic [CW-1:0] msg_len;

    assign req         = start && !busy;
    assign full        = (r_count == LEN_MAX);
    assign wr_en       = req && !full;
    assign k_ext       = CW'(r_k);
    assign msg_len     = full ? r_count : r_count + CW'(1);
    assign o_cfg_ready = 1'b1;

    // Source position for output slot k
    always_comb begin
        if (!r_decrypt) begin
            if (k_ext < r_half) begin
                src = k_ext << 1;
            end else begin
                src = ((k_ext - r_half) << 1) | CW'(1);
            end
        end else begin
            if (!k_ext[0]) begin
                src = k_ext >> 1;
            end else begin
                src = r_half + (k_ext >> 1);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_n       = r_n;
        n_half    = r_half;
        n_k       = r_k;
        n_ovf     = r_ovf;
        n_rd_vld  = 1'b0;
        n_rd_last = 1'b0;
        n_rd_ovf  = r_ovf;
        busy      = 1'b0;
        unique case (r_state)
            trtc_pkg::S_LOAD: begin
                if (req) begin
                    if (wr_en) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_end_of_message) begin
                        n_n     = msg_len;
                        // ceil(n/2) without growing past the count width
                        n_half  = msg_len - (msg_len >> 1);
                        n_k     = '0;
                        n_state = trtc_pkg::S_EMIT;
                    end
                end
            end
            trtc_pkg::S_EMIT: begin
                busy      = 1'b1;
                n_rd_vld  = 1'b1;
                n_rd_last = (k_ext == r_n - CW'(1));
                n_k       = r_k + AW'(1);
                // last read issued: drop the message and reopen for loading
                if (n_rd_last) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = trtc_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = trtc_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= trtc_pkg::S_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_decrypt <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_rd_vld <= n_rd_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_decrypt <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_half    <= n_half;
        r_k       <= n_k;
        r_rd_last <= n_rd_last;
        r_rd_ovf  <= n_rd_ovf;
    end

    trtc_ram #(
        .WIDTH(8),
        .DEPTH(MAX_LEN)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_data_byte),
        .i_raddr(src[AW-1:0]),
        .o_rdata(o_out_byte)
    );

    assign o_strobe      = r_rd_vld;
    assign o_last_of_run = r_rd_last;
    assign o_overflow    = r_rd_ovf;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_MAX)
        else $error("byte count above buffer size");

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == trtc_pkg::S_EMIT))
        else $error("result without a preceding read");

    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_of_run) |-> (r_state == trtc_pkg::S_LOAD && r_count <= CW'(1)))
        else $error("last result while still emitting");

    a_emit_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == trtc_pkg::S_EMIT) |-> !wr_en)
        else $error("buffer written during a run");
`endif

endmodule

/* rtl/trtc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trtc_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module trtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* dv/two_rail_transposition_cipher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_rail_transposition_cipher_tb
// Self-checking bench for the two-rail transposition cipher.
// ----------------------------------------------------------------------------
// Messages are fed one byte per request. A directed set covers one-byte
// messages, extreme byte values and odd and even lengths in both modes. Random
// messages follow, mostly short, with a few that fill or overrun the buffer.
// A scoreboard keeps its own copy of the buffer and the mode. It builds the
// permuted run when the end mark is accepted and compares every strobed result
// field by field, in order. The mode is changed only after the block drains.
// ----------------------------------------------------------------------------
module two_rail_transposition_cipher_tb;

    localparam int   BUF_DEPTH    = trtc_pkg::MAX_LEN_DEF;
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;
    localparam int   STALL_LIMIT  = 1000;
    localparam int   RANDOM_ITEMS = 340;
    localparam int   SETTLE_CYCLES = 4;

    typedef logic [7:0] t_msg[$];

    typedef struct {
        logic [7:0] text;
        logic       last;
        logic       ovf;
    } t_rail_byte;

    class t_rail_scoreboard;
        logic [7:0] held[$];
        logic       dropped;
        logic       decrypt;
        t_rail_byte permuted[$];
        int         errors;

        function new();
            dropped = 1'b0;
            decrypt = MODE_ENCRYPT;
            errors  = 0;
        endfunction

        // Buffer one request; on the end mark, queue the whole permuted run.
        function void note_request(logic [7:0] data, logic eom);
            int n;
            int half;
            int k;
            int src;
            t_rail_byte r;
            if (held.size() < BUF_DEPTH) begin
                held.push_back(data);
            end else begin
                dropped = 1'b1;
            end
            if (!eom) begin
                return;
            end
            n    = held.size();
            half = (n + 1) / 2;
            for (k = 0; k < n; k++) begin
                if (decrypt) begin
                    // even slots come from the front half, odd slots from the back
                    src = (k % 2 == 0) ? k / 2 : half + k / 2;
                end else begin
                    src = (k < half) ? 2 * k : 2 * (k - half) + 1;
                end
                r.text = held[src];
                r.last = (k == n - 1);
                r.ovf  = dropped;
                permuted.push_back(r);
            end
            held.delete();
            dropped = 1'b0;
        endfunction

        function void check_result(logic [7:0] text, logic last, logic ovf);
            t_rail_byte want;
            if (permuted.size() == 0) begin
                $error("unexpected result: out_byte %0h last_of_run %0b overflow %0b",
                       text, last, ovf);
                errors++;
                return;
            end
            want = permuted.pop_front();
            if (text !== want.text) begin
                $error("out_byte: expected %0h, actual %0h", want.text, text);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0b, actual %0b", want.last, last);
                errors++;
            end
            if (ovf !== want.ovf) begin
                $error("overflow: expected %0b, actual %0b", want.ovf, ovf);
                errors++;
            end
        endfunction

        function int pending();
            return permuted.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_data_byte;
    logic       i_end_of_message;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;
    logic       o_strobe;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       o_overflow;

    t_rail_scoreboard sb;
    int stall_cycles = 0;

    two_rail_transposition_cipher dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_out_byte       (o_out_byte),
        .o_last_of_run    (o_last_of_run),
        .o_overflow       (o_overflow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Check results before noting requests so a run ending on this edge is
    // matched ahead of a new one-byte message accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_result(o_out_byte, o_last_of_run, o_overflow);
            end
            if (start && !busy) begin
                sb.note_request(i_data_byte, i_end_of_message);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.decrypt = i_cfg_data;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("two_rail_transposition_cipher verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_msg random_message(int len);
        t_msg m;
        int i;
        for (i = 0; i < len; i++) begin
            m.push_back(8'($urandom_range(0, 255)));
        end
        return m;
    endfunction

    // Hold the request until the block takes it.
    task automatic send_byte(input logic [7:0] data, input logic eom);
        start            <= 1'b1;
        i_data_byte      <= data;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic send_message(input t_msg msg, input bit burst);
        int i;
        for (i = 0; i < msg.size(); i++) begin
            send_byte(msg[i], i == msg.size() - 1);
            if (!burst) begin
                pause(pick_gap());
            end
        end
    endtask

    // Drop start, let the last request reach the scoreboard, then wait until
    // every queued result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int   sent;
        int   len;
        t_msg msg;
        sb               = new();
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_data_byte      = 8'h00;
        i_end_of_message = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(MODE_ENCRYPT);
        msg = '{8'h00};
        send_message(msg, 1'b0);
        msg = '{8'hFF};
        send_message(msg, 1'b1);
        msg = '{8'hA5, 8'h5A};
        send_message(msg, 1'b0);
        msg = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F};
        send_message(msg, 1'b1);
        drain();

        write_mode(MODE_DECRYPT);
        msg = '{8'hFF};
        send_message(msg, 1'b1);
        msg = '{8'h00, 8'hFF};
        send_message(msg, 1'b0);
        msg = '{8'h10, 8'h21, 8'h32, 8'h43, 8'h54, 8'h65};
        send_message(msg, 1'b1);
        msg = '{8'hFE, 8'h01, 8'h7F, 8'h80, 8'hAA};
        send_message(msg, 1'b0);
        drain();

        // one exactly full buffer, then one that overruns it
        write_mode(1'($urandom_range(0, 1)));
        send_message(random_message(BUF_DEPTH), 1'($urandom_range(0, 1)));
        send_message(random_message(BUF_DEPTH + 2), 1'($urandom_range(0, 1)));
        sent = 2 * BUF_DEPTH + 2;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                len = $urandom_range(BUF_DEPTH - 4, BUF_DEPTH + 6);
            end else begin
                len = $urandom_range(1, 10);
            end
            send_message(random_message(len), $urandom_range(0, 3) == 0);
            sent += len;
            if ($urandom_range(0, 5) == 0) begin
                drain();
                if ($urandom_range(0, 1) == 1) begin
                    write_mode(1'($urandom_range(0, 1)));
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("two_rail_transposition_cipher verification clean");
        end else begin
            $display("two_rail_transposition_cipher verification failed");
        end
        $finish;
    end

endmodule

/* two_rail_transposition_cipher.f */
rtl/trtc_pkg.sv
rtl/trtc_ram.sv
rtl/two_rail_transposition_cipher.sv
dv/two_rail_transposition_cipher_tb.sv
